[rtl/core/lfu_pkg.sv]
// ----------------------------------------------------------------------------
// lfu_pkg
// Shared constants, types and helpers for the LFU page replacement block.
// ----------------------------------------------------------------------------
package lfu_pkg;

	localparam int FRAMES    = 8;
	localparam int PAGE_BITS = 16;

	localparam int FIDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
	localparam int FCNT_W = $clog2(FRAMES + 1);
	localparam int TAG_W  = PAGE_BITS;
	localparam int CNT_W  = 16;
	localparam int STAMP_W = 32;
	localparam int FAULT_W = 32;

	localparam int PAGE_IN_W = 16;
	localparam int CFG_W     = 4;
	localparam int SLOT_W    = 3;
	localparam int OUT_W     = 56;

	localparam logic [CFG_W-1:0] CFG_RESET = 4'd8;

	typedef struct packed {
		logic start;   // latch the accepted reference, restart the scan
		logic step;    // examine one frame
		logic commit;  // update the table and load the result register
	} lfu_cmd_t;

	typedef struct packed {
		logic scan_last;  // frame under examination is the last one in use
	} lfu_sts_t;

	function automatic logic [TAG_W-1:0] mask_page(input logic [PAGE_IN_W-1:0] p);
		logic [31:0] wide;
		wide = {16'd0, p};
		return wide[TAG_W-1:0];
	endfunction

endpackage

[rtl/core/lfu_page_replacement.sv]
// ----------------------------------------------------------------------------
// lfu_page_replacement
// LFU page replacement with oldest-stamp then lowest-index tie-break.
// ----------------------------------------------------------------------------
//  channel   direction  ports                      contents
//  s_axis    in         tvalid/tready/tdata/tlast  page reference, end of run
//  m_axis    out        tvalid/tready/tdata        hit, slot, eviction, faults
//  cfg       in         cfg_we/cfg_wdata           frames_in_use
//
//  An item is accepted, then the n frames in use are scanned one per cycle
//  (n = frames_in_use clamped to 1..8), then the table is updated.
//  Reset clears the table at once: valid marks are flops, no clearing pass.
//  The update waits while an earlier result has not been transferred.
//  Input is refused from accept until the update; results wait in a register.
// ----------------------------------------------------------------------------
module lfu_page_replacement (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,   // page_number[15:0]
	input  logic        s_axis_tlast,   // last_reference
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// hit[0], slot[3:1], filled_empty[4], evicted_valid[5],
	// evicted_page[21:6], fault_total[53:22], zero fill[55:54]
	output logic [55:0] m_axis_tdata,
	input  logic        cfg_we,
	input  logic [3:0]  cfg_wdata      // frames_in_use
);
	import lfu_pkg::*;

	lfu_cmd_t cmd;
	lfu_sts_t sts;

	lfu_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_axis_tvalid),
		.s_tready (s_axis_tready),
		.m_tvalid (m_axis_tvalid),
		.m_tready (m_axis_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	lfu_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_page   (s_axis_tdata),
		.in_last   (s_axis_tlast),
		.cmd       (cmd),
		.sts       (sts),
		.out_data  (m_axis_tdata)
	);

endmodule

[rtl/core/lfu_ctrl.sv]
// ----------------------------------------------------------------------------
// lfu_ctrl
// Sequencer: accept a reference, scan the frames in use, then commit.
// ----------------------------------------------------------------------------
module lfu_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	output logic              m_tvalid,
	input  logic              m_tready,
	input  lfu_pkg::lfu_sts_t sts,
	output lfu_pkg::lfu_cmd_t cmd
);
	import lfu_pkg::*;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_COMMIT
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_valid_q;
	assign out_free = !out_valid_q || m_tready;

	always_comb begin
		cmd = '0;
		case (state_q)
			ST_IDLE:   cmd.start  = s_tvalid;
			ST_SCAN:   cmd.step   = 1'b1;
			ST_COMMIT: cmd.commit = out_free;
			default:   cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			// load on commit, drop once the downstream transfer completes
			out_valid_q <= cmd.commit || (out_valid_q && !m_tready);
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid)
						state_q <= ST_SCAN;
				end
				ST_SCAN: begin
					if (sts.scan_last)
						state_q <= ST_COMMIT;
				end
				ST_COMMIT: begin
					if (out_free)
						state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_commit_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |-> (!out_valid_q || m_tready))
		else $error("commit while result register still occupied");

	a_commit_loads_result: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit |=> out_valid_q && state_q == ST_IDLE)
		else $error("commit did not present a result");

	a_start_enters_scan: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.start |=> state_q == ST_SCAN && !s_tready)
		else $error("accepted reference did not start a scan");
`endif

endmodule

[rtl/core/lfu_dp.sv]
// ----------------------------------------------------------------------------
// lfu_dp
// Frame table, scan trackers, stamp and fault counters, result register.
// ----------------------------------------------------------------------------
module lfu_dp (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [lfu_pkg::CFG_W-1:0]      cfg_wdata,
	input  logic [lfu_pkg::PAGE_IN_W-1:0]  in_page,
	input  logic                           in_last,
	input  lfu_pkg::lfu_cmd_t              cmd,
	output lfu_pkg::lfu_sts_t              sts,
	output logic [lfu_pkg::OUT_W-1:0]      out_data
);
	import lfu_pkg::*;

	logic [CFG_W-1:0]   cfg_q;
	logic [TAG_W-1:0]   page_q;
	logic               last_q;

	logic [TAG_W-1:0]   tag_q   [FRAMES];
	logic [CNT_W-1:0]   cnt_q   [FRAMES];
	logic [STAMP_W-1:0] stamp_q [FRAMES];
	logic [FRAMES-1:0]  valid_q;

	logic [STAMP_W-1:0] access_q;
	logic [FAULT_W-1:0] fault_q;

	logic [FIDX_W-1:0]  idx_q;
	logic               hit_q;
	logic [FIDX_W-1:0]  hit_idx_q;
	logic               empty_q;
	logic [FIDX_W-1:0]  empty_idx_q;
	logic [FIDX_W-1:0]  best_idx_q;
	logic [CNT_W-1:0]   best_cnt_q;
	logic [STAMP_W-1:0] best_stamp_q;

	logic [OUT_W-1:0]   out_q;

	logic [7:0]         cfg_wide;
	logic [FCNT_W-1:0]  n_act;
	logic [FIDX_W-1:0]  n_last;
	logic               rd_valid;
	logic [TAG_W-1:0]   rd_tag;
	logic [CNT_W-1:0]   rd_cnt;
	logic [STAMP_W-1:0] rd_stamp;
	logic               better;
	logic [FIDX_W-1:0]  slot_sel;
	logic [STAMP_W-1:0] stamp_next;
	logic [FAULT_W-1:0] fault_next;
	logic [CNT_W-1:0]   cnt_inc;
	logic [7:0]         slot_wide;
	logic [31:0]        evict_wide;
	logic               evicting;

	// clamp the register to 1..FRAMES
	always_comb begin
		cfg_wide = {4'd0, cfg_q};
		if (cfg_q == '0)
			n_act = FCNT_W'(1);
		else if (cfg_wide > 8'(FRAMES))
			n_act = FCNT_W'(FRAMES);
		else
			n_act = FCNT_W'(cfg_wide);
		n_last = FIDX_W'(n_act - FCNT_W'(1));
	end

	assign sts.scan_last = (idx_q == n_last);

	assign rd_valid = valid_q[idx_q];
	assign rd_tag   = tag_q[idx_q];
	assign rd_cnt   = cnt_q[idx_q];
	assign rd_stamp = stamp_q[idx_q];

	// lower count wins; on equal count the older stamp wins; first frame seeds
	assign better = (idx_q == '0) || (rd_cnt < best_cnt_q) ||
		((rd_cnt == best_cnt_q) && (rd_stamp < best_stamp_q));

	always_comb begin
		if (hit_q)
			slot_sel = hit_idx_q;
		else if (empty_q)
			slot_sel = empty_idx_q;
		else
			slot_sel = best_idx_q;
		evicting   = !hit_q && !empty_q;
		stamp_next = access_q + STAMP_W'(1);
		fault_next = (hit_q || fault_q == '1) ? fault_q : fault_q + FAULT_W'(1);
		cnt_inc    = (cnt_q[slot_sel] == '1) ? cnt_q[slot_sel] :
			cnt_q[slot_sel] + CNT_W'(1);
		slot_wide  = 8'(slot_sel);
		evict_wide = evicting ? 32'(tag_q[slot_sel]) : 32'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			cfg_q <= CFG_RESET;
		else if (cfg_we)
			cfg_q <= cfg_wdata;
	end

	// scan trackers
	always_ff @(posedge clk) begin
		if (cmd.start) begin
			page_q  <= mask_page(in_page);
			last_q  <= in_last;
			idx_q   <= '0;
			hit_q   <= 1'b0;
			empty_q <= 1'b0;
		end else if (cmd.step) begin
			idx_q <= idx_q + FIDX_W'(1);
			if (!hit_q && rd_valid && rd_tag == page_q) begin
				hit_q     <= 1'b1;
				hit_idx_q <= idx_q;
			end
			if (!empty_q && !rd_valid) begin
				empty_q     <= 1'b1;
				empty_idx_q <= idx_q;
			end
			if (better) begin
				best_idx_q   <= idx_q;
				best_cnt_q   <= rd_cnt;
				best_stamp_q <= rd_stamp;
			end
		end
	end

	// frame payload: written only on commit
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			stamp_q[slot_sel] <= stamp_next;
			if (hit_q) begin
				cnt_q[slot_sel] <= cnt_inc;
			end else begin
				cnt_q[slot_sel] <= CNT_W'(1);
				tag_q[slot_sel] <= page_q;
			end
			out_q <= {2'd0, fault_next, evict_wide[15:0], evicting, !hit_q && empty_q,
				slot_wide[SLOT_W-1:0], hit_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q  <= '0;
			access_q <= '0;
			fault_q  <= '0;
		end else if (cmd.commit) begin
			if (last_q) begin
				// end of run: clear after this result
				valid_q  <= '0;
				access_q <= '0;
				fault_q  <= '0;
			end else begin
				valid_q[slot_sel] <= 1'b1;
				access_q          <= stamp_next;
				fault_q           <= fault_next;
			end
		end
	end

	assign out_data = out_q;

`ifndef SYNTHESIS
	a_last_clears: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit && last_q |=> valid_q == '0 && fault_q == '0 && access_q == '0)
		else $error("state not cleared after last reference");

	a_fill_marks_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.commit && !last_q |=> valid_q[$past(slot_sel)])
		else $error("committed frame not valid");

	a_scan_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |-> idx_q <= n_last)
		else $error("scan beyond frames in use");
`endif

endmodule
